FILE: hdl/mspid_pkg.sv
// ----------------------------------------------------------------------------
// mspid_pkg
// Shared widths, register indexes and constants of the motor speed PID loop.
// ----------------------------------------------------------------------------
package mspid_pkg;

  localparam int MEAS_WIDTH  = 16;
  localparam int DRIVE_WIDTH = 10;
  localparam int DUTY_WIDTH  = 8;
  localparam int GAIN_WIDTH  = 8;
  localparam int CFG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 3;
  localparam int ERR_WIDTH   = 18;

  localparam int FULL_SCALE  = 255;
  localparam int DRIVE_MIN   = 5;
  localparam int DRIVE_MAX   = 760;
  // thresholds on the triple-scaled PID sum
  localparam int SUM_LOW     = 3 * DRIVE_MIN;
  localparam int SUM_HIGH    = 3 * DRIVE_MAX;
  // floor(s/3) == (s * 2731) >> 13 for 0 <= s < 2280
  localparam int RECIP3      = 2731;
  localparam int RECIP3_SHIFT = 13;
  localparam int QUOT_WIDTH  = 12;

  localparam logic [GAIN_WIDTH-1:0] TARGET_RESET = 8'd205;
  localparam logic [GAIN_WIDTH-1:0] PROP_RESET   = 8'd7;
  localparam logic [GAIN_WIDTH-1:0] INT_RESET    = 8'd1;
  localparam logic [GAIN_WIDTH-1:0] DERIV_RESET  = 8'd14;
  localparam logic [CFG_WIDTH-1:0]  WINDOW_RESET = 16'd100;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_TARGET_SETTING = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_INT_GAIN       = 3'd2,
    REG_DERIV_GAIN     = 3'd3,
    REG_WINDOW_TICKS   = 3'd4
  } reg_index_t;

endpackage

FILE: hdl/mspid_sample_if.sv
// ----------------------------------------------------------------------------
// mspid_sample_if
// Input channel: one encoder pulse flag and one timer tick flag per item.
// ----------------------------------------------------------------------------
interface mspid_sample_if;
  logic valid;
  logic ready;
  logic pulse;
  logic tick;

  modport source (output valid, output pulse, output tick, input ready);
  modport sink   (input valid, input pulse, input tick, output ready);
endinterface

FILE: hdl/mspid_result_if.sv
// ----------------------------------------------------------------------------
// mspid_result_if
// Result channel: pulse total, drive level and duty byte of a closed window.
// ----------------------------------------------------------------------------
interface mspid_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [mspid_pkg::MEAS_WIDTH-1:0]      measured_pulses;
  logic [mspid_pkg::DRIVE_WIDTH-1:0]     drive_level;
  logic [mspid_pkg::DUTY_WIDTH-1:0]      duty_byte;

  modport source (output valid, output measured_pulses, output drive_level,
                  output duty_byte, input ready);
  modport sink   (input valid, input measured_pulses, input drive_level,
                  input duty_byte, output ready);
endinterface

FILE: hdl/motor_speed_pid_loop_top.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_loop_top
// Encoder pulse / tick counter with a windowed positional PID in exact
// triple-scaled integer form and a clamped drive output.
// ----------------------------------------------------------------------------
// Throughput: one input item per cycle unless stalled; counted at acceptance.
// Path: a window-closing item is latched at the accepting edge and passes the
//   error, integrate, multiply, add, clamp and divide registers before
//   result.valid rises.
// Stages advance independently, so bubbles collapse under output stalls.
// Reset (rst, synchronous) clears counters and PID state, empties the pipeline
//   and loads the default register values.
module motor_speed_pid_loop_top #(
  parameter int COUNT_WIDTH = 16,
  parameter int SUM_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [mspid_pkg::IDX_WIDTH-1:0]      wr_index,
  input  logic [mspid_pkg::CFG_WIDTH-1:0]      wr_data,
  mspid_sample_if.sink                         sample,
  mspid_result_if.source                       result
);

  localparam int EW   = mspid_pkg::ERR_WIDTH;
  localparam int DW   = (COUNT_WIDTH + 2 > EW) ? COUNT_WIDTH + 2 : EW;
  localparam int CMPW = (COUNT_WIDTH > mspid_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                             : mspid_pkg::CFG_WIDTH;
  localparam int GW   = mspid_pkg::GAIN_WIDTH;
  localparam int AW   = SUM_WIDTH + 1;
  localparam int PW   = EW + GW + 1;
  localparam int DPW  = EW + GW + 2;
  localparam int IPW  = SUM_WIDTH + GW + 1;
  localparam int SW   = SUM_WIDTH + GW + 2;
  localparam int MW   = mspid_pkg::MEAS_WIDTH;
  localparam int QW   = mspid_pkg::QUOT_WIDTH;
  localparam int XW   = 2 * QW;
  localparam int RW   = mspid_pkg::DRIVE_WIDTH;

  localparam logic signed [DW-1:0] ERR_HI = DW'(2 ** (EW - 1) - 1);
  localparam logic signed [DW-1:0] ERR_LO = -ERR_HI - DW'(1);

  // configuration
  logic [GW-1:0]                   target_setting;
  logic [GW-1:0]                   prop_gain;
  logic [GW-1:0]                   int_gain;
  logic [GW-1:0]                   deriv_gain;
  logic [mspid_pkg::CFG_WIDTH-1:0] window_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_setting <= mspid_pkg::TARGET_RESET;
      prop_gain      <= mspid_pkg::PROP_RESET;
      int_gain       <= mspid_pkg::INT_RESET;
      deriv_gain     <= mspid_pkg::DERIV_RESET;
      window_ticks   <= mspid_pkg::WINDOW_RESET;
    end else if (wr_en) begin
      case (mspid_pkg::reg_index_t'(wr_index))
        mspid_pkg::REG_TARGET_SETTING: target_setting <= wr_data[GW-1:0];
        mspid_pkg::REG_PROP_GAIN:      prop_gain      <= wr_data[GW-1:0];
        mspid_pkg::REG_INT_GAIN:       int_gain       <= wr_data[GW-1:0];
        mspid_pkg::REG_DERIV_GAIN:     deriv_gain     <= wr_data[GW-1:0];
        mspid_pkg::REG_WINDOW_TICKS:   window_ticks   <= wr_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage ready chain
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready, s7_ready;

  assign s7_ready = !s7_valid || result.ready;
  assign s6_ready = !s6_valid || s7_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign sample.ready = s1_ready;

  // counters
  logic [COUNT_WIDTH-1:0] pulse_count;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] pulse_count_next;
  logic [COUNT_WIDTH-1:0] tick_count_inc;
  logic                   accept;
  logic                   close;

  assign accept           = sample.valid && s1_ready;
  assign pulse_count_next = sample.pulse ? pulse_count + COUNT_WIDTH'(1) : pulse_count;
  assign tick_count_inc   = tick_count + COUNT_WIDTH'(1);
  assign close            = sample.tick && (CMPW'(tick_count_inc) > CMPW'(window_ticks));

  // stage 1: latched pulse total
  logic [COUNT_WIDTH-1:0] s1_meas;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      tick_count  <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (close) begin
          pulse_count <= '0;
          tick_count  <= '0;
        end else begin
          pulse_count <= pulse_count_next;
          if (sample.tick) begin
            tick_count <= tick_count_inc;
          end
        end
      end
      if (s1_ready) begin
        s1_valid <= accept && close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && close) begin
      s1_meas <= pulse_count_next;
    end
  end

  // stage 2: scaled error, saturated to the error width
  logic signed [DW-1:0] tgt3;
  logic signed [DW-1:0] diff;
  logic signed [EW-1:0] e3_next;
  logic signed [EW-1:0] s2_e3;
  logic [MW-1:0]        s2_meas;
  logic [31:0]          meas_ext;

  assign tgt3     = DW'(3 * (mspid_pkg::FULL_SCALE - int'(target_setting)));
  assign diff     = tgt3 - $signed(DW'(s1_meas));
  assign meas_ext = 32'(s1_meas);

  always_comb begin
    if (diff > ERR_HI) begin
      e3_next = ERR_HI[EW-1:0];
    end else if (diff < ERR_LO) begin
      e3_next = ERR_LO[EW-1:0];
    end else begin
      e3_next = diff[EW-1:0];
    end
  end

  // stage 3: integral with saturation, derivative difference
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [EW-1:0]        last_scaled_error;
  logic signed [AW-1:0]        sum_wide;
  logic signed [SUM_WIDTH-1:0] error_sum_next;
  logic signed [EW:0]          d3_next;
  logic signed [EW-1:0]        s3_e3;
  logic signed [EW:0]          s3_d3;
  logic signed [SUM_WIDTH-1:0] s3_sum;
  logic [MW-1:0]               s3_meas;

  assign sum_wide = $signed({error_sum[SUM_WIDTH-1], error_sum}) + AW'(s2_e3);
  assign d3_next  = (EW + 1)'(s2_e3) - (EW + 1)'(last_scaled_error);

  always_comb begin
    if (sum_wide[AW-1] != sum_wide[AW-2]) begin
      // overflow: pin to the end of the range on the side of the true sign
      error_sum_next = sum_wide[AW-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // stage 4: gain products
  logic signed [PW-1:0]  s4_pp;
  logic signed [IPW-1:0] s4_ip;
  logic signed [DPW-1:0] s4_dp;
  logic [MW-1:0]         s4_meas;

  // stage 5: PID sum (three times the real output)
  logic signed [SW-1:0]  s5_sum;
  logic [MW-1:0]         s5_meas;

  // stage 6: clamp decision
  logic                  s6_low;
  logic                  s6_high;
  logic [QW-1:0]         s6_part;
  logic [MW-1:0]         s6_meas;

  // stage 7: result register
  logic [XW-1:0]         quot_prod;
  logic [RW-1:0]         drive_next;
  logic [RW-1:0]         s7_drive;
  logic [MW-1:0]         s7_meas;

  assign quot_prod = XW'(s6_part) * XW'(mspid_pkg::RECIP3);

  always_comb begin
    if (s6_low) begin
      drive_next = RW'(mspid_pkg::DRIVE_MIN);
    end else if (s6_high) begin
      drive_next = RW'(mspid_pkg::DRIVE_MAX);
    end else begin
      drive_next = quot_prod[mspid_pkg::RECIP3_SHIFT +: RW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid          <= 1'b0;
      s3_valid          <= 1'b0;
      s4_valid          <= 1'b0;
      s5_valid          <= 1'b0;
      s6_valid          <= 1'b0;
      s7_valid          <= 1'b0;
      error_sum         <= '0;
      last_scaled_error <= '0;
    end else begin
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
      if (s7_ready) s7_valid <= s6_valid;
      // PID state moves once per item, as it enters stage 3
      if (s3_ready && s2_valid) begin
        error_sum         <= error_sum_next;
        last_scaled_error <= s2_e3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_e3   <= e3_next;
      s2_meas <= meas_ext[MW-1:0];
    end
    if (s3_ready && s2_valid) begin
      s3_e3   <= s2_e3;
      s3_d3   <= d3_next;
      s3_sum  <= error_sum_next;
      s3_meas <= s2_meas;
    end
    if (s4_ready && s3_valid) begin
      s4_pp   <= PW'($signed({1'b0, prop_gain})) * PW'(s3_e3);
      s4_ip   <= IPW'($signed({1'b0, int_gain})) * IPW'(s3_sum);
      s4_dp   <= DPW'($signed({1'b0, deriv_gain})) * DPW'(s3_d3);
      s4_meas <= s3_meas;
    end
    if (s5_ready && s4_valid) begin
      s5_sum  <= SW'(s4_pp) + SW'(s4_ip) + SW'(s4_dp);
      s5_meas <= s4_meas;
    end
    if (s6_ready && s5_valid) begin
      s6_low  <= s5_sum <= SW'(mspid_pkg::SUM_LOW);
      s6_high <= s5_sum >= SW'(mspid_pkg::SUM_HIGH);
      s6_part <= s5_sum[QW-1:0];
      s6_meas <= s5_meas;
    end
    if (s7_ready && s6_valid) begin
      s7_drive <= drive_next;
      s7_meas  <= s6_meas;
    end
  end

  assign result.valid           = s7_valid;
  assign result.measured_pulses = s7_meas;
  assign result.drive_level     = s7_drive;
  assign result.duty_byte       = 8'(mspid_pkg::FULL_SCALE) - s7_drive[7:0];

endmodule

FILE: bench/motor_speed_pid_loop_top_tb.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_loop_top_tb
// Self-checking bench for the windowed pulse counter and positional PID.
// Items are fed from a queue through a valid/ready driver. Each accepted
// item updates a local model of the counters and of the triple-scaled PID.
// Every closed window queues an expected result, and the monitor checks
// each arriving result against it. Phases change the settings while the
// block is idle: reset defaults, both ends of the gains and setpoint,
// window 0 and 65535, ignored register indexes, then random traffic with
// random idle cycles on both sides.
// ----------------------------------------------------------------------------
module motor_speed_pid_loop_top_tb;

  localparam int     CLK_PERIOD    = 20;
  localparam int     RESET_CYCLES  = 12;
  localparam int     SETTLE_CYCLES = 12;
  localparam longint LIMIT_CYCLES  = 1500000;
  localparam int     RANDOM_ITEMS  = 1550;
  localparam int     WIDE_WINDOW_ITEMS = 40;
  localparam int     COUNT_BITS    = 16;
  localparam int     SUM_BITS      = 32;
  localparam int     IDX_BITS      = mspid_pkg::IDX_WIDTH;
  localparam int     CFG_BITS      = mspid_pkg::CFG_WIDTH;
  localparam int     DRIVE_BITS    = mspid_pkg::DRIVE_WIDTH;
  localparam int     DUTY_BITS     = mspid_pkg::DUTY_WIDTH;
  localparam logic [IDX_BITS-1:0] FIRST_UNMAPPED_INDEX = 3'd5;

  typedef struct packed {
    logic                   pulse;
    logic                   tick;
  } sample_t;

  typedef struct packed {
    logic [mspid_pkg::MEAS_WIDTH-1:0] measured_pulses;
    logic [DRIVE_BITS-1:0]            drive_level;
    logic [DUTY_BITS-1:0]             duty_byte;
  } window_result_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_index;
  logic [CFG_BITS-1:0]  wr_data;

  mspid_sample_if sample();
  mspid_result_if result();

  motor_speed_pid_loop_top #(
    .COUNT_WIDTH(COUNT_BITS),
    .SUM_WIDTH(SUM_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .sample(sample),
    .result(result)
  );

  // local copy of the settings and of the loop state
  logic [mspid_pkg::GAIN_WIDTH-1:0] target_q = mspid_pkg::TARGET_RESET;
  logic [mspid_pkg::GAIN_WIDTH-1:0] kp_q     = mspid_pkg::PROP_RESET;
  logic [mspid_pkg::GAIN_WIDTH-1:0] ki_q     = mspid_pkg::INT_RESET;
  logic [mspid_pkg::GAIN_WIDTH-1:0] kd_q     = mspid_pkg::DERIV_RESET;
  logic [CFG_BITS-1:0]   window_q = mspid_pkg::WINDOW_RESET;
  logic [COUNT_BITS-1:0] pulse_total = '0;
  logic [COUNT_BITS-1:0] tick_total  = '0;
  longint                last_err3   = 0;
  longint                err_sum     = 0;

  sample_t        pending_samples[$];
  window_result_t expected_windows[$];

  int samples_pushed = 0;
  int samples_taken  = 0;
  int windows_seen   = 0;
  int errors         = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  bit gaps_on        = 1'b1;
  bit stalls_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("motor_speed_pid_loop_top_tb: errors");
    $finish;
  end

  function automatic longint sat_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one PID update on a closed window; returns the clamped drive level
  function automatic logic [DRIVE_BITS-1:0] pid_drive(int meas);
    longint e3;
    longint d3;
    longint s;
    e3 = sat_signed(3 * (mspid_pkg::FULL_SCALE - int'(target_q)) - meas,
                    mspid_pkg::ERR_WIDTH);
    err_sum = sat_signed(err_sum + e3, SUM_BITS);
    d3 = e3 - last_err3;
    last_err3 = e3;
    s = longint'(int'(kp_q)) * e3 + longint'(int'(ki_q)) * err_sum
        + longint'(int'(kd_q)) * d3;
    if (s <= mspid_pkg::SUM_LOW) return DRIVE_BITS'(mspid_pkg::DRIVE_MIN);
    if (s >= mspid_pkg::SUM_HIGH) return DRIVE_BITS'(mspid_pkg::DRIVE_MAX);
    return DRIVE_BITS'(s / 3);
  endfunction

  function automatic void track_sample(logic pulse, logic tick);
    window_result_t r;
    logic [DRIVE_BITS-1:0] drive;
    if (pulse) pulse_total++;
    if (tick) begin
      tick_total++;
      if (tick_total > window_q) begin
        r.measured_pulses = pulse_total;
        tick_total  = '0;
        pulse_total = '0;
        drive = pid_drive(int'(r.measured_pulses));
        r.drive_level = drive;
        r.duty_byte   = DUTY_BITS'(mspid_pkg::FULL_SCALE - int'(drive));
        expected_windows.push_back(r);
      end
    end
  endfunction

  // mostly short idles, now and then a long one
  function automatic int pick_idle(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : feed_samples
    sample_t next_item;
    logic    holding;
    if (rst) begin
      sample.valid <= 1'b0;
      send_gap = 0;
    end else begin
      holding = sample.valid;
      if (sample.valid && sample.ready) begin
        track_sample(sample.pulse, sample.tick);
        samples_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          sample.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_item = pending_samples.pop_front();
          sample.valid <= 1'b1;
          sample.pulse <= next_item.pulse;
          sample.tick  <= next_item.tick;
          send_gap = pick_idle(gaps_on);
        end else begin
          sample.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_windows
    window_result_t want;
    if (rst) begin
      result.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result.valid && result.ready) begin
        windows_seen++;
        if (expected_windows.size() == 0) begin
          $error("unexpected result: measured_pulses %0d drive_level %0d duty_byte %0d",
                 result.measured_pulses, result.drive_level, result.duty_byte);
          errors++;
        end else begin
          want = expected_windows.pop_front();
          if (result.measured_pulses !== want.measured_pulses) begin
            $error("measured_pulses: expected %0d, got %0d",
                   want.measured_pulses, result.measured_pulses);
            errors++;
          end
          if (result.drive_level !== want.drive_level) begin
            $error("drive_level: expected %0d, got %0d",
                   want.drive_level, result.drive_level);
            errors++;
          end
          if (result.duty_byte !== want.duty_byte) begin
            $error("duty_byte: expected %0d, got %0d",
                   want.duty_byte, result.duty_byte);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        stall_left = pick_idle(stalls_on);
      end
    end
  end

  task automatic write_setting(logic [IDX_BITS-1:0] idx, int value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= CFG_BITS'(value);
    case (idx)
      mspid_pkg::REG_TARGET_SETTING: target_q = value[7:0];
      mspid_pkg::REG_PROP_GAIN:      kp_q     = value[7:0];
      mspid_pkg::REG_INT_GAIN:       ki_q     = value[7:0];
      mspid_pkg::REG_DERIV_GAIN:     kd_q     = value[7:0];
      mspid_pkg::REG_WINDOW_TICKS:   window_q = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // 8-bit registers get junk in the upper byte, which must be dropped
  task automatic load_settings(int target, int kp, int ki, int kd, int window);
    write_setting(mspid_pkg::REG_TARGET_SETTING, ($urandom_range(0, 255) << 8) | target);
    write_setting(mspid_pkg::REG_PROP_GAIN,      ($urandom_range(0, 255) << 8) | kp);
    write_setting(mspid_pkg::REG_INT_GAIN,       ($urandom_range(0, 255) << 8) | ki);
    write_setting(mspid_pkg::REG_DERIV_GAIN,     ($urandom_range(0, 255) << 8) | kd);
    write_setting(mspid_pkg::REG_WINDOW_TICKS, window);
  endtask

  task automatic push_sample(logic pulse, logic tick);
    pending_samples.push_back('{pulse: pulse, tick: tick});
    samples_pushed++;
  endtask

  // wait until every item is taken and every window result has come back
  task automatic settle();
    while (samples_taken != samples_pushed || expected_windows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    if (r < 6) return $urandom_range(0, 20);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1);
    if (r == 1) return $urandom_range(254, 255);
    return $urandom_range(1, 254);
  endfunction

  function automatic int pick_window();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 4);
    if (r < 18) return $urandom_range(5, 30);
    if (r == 18) return 255;
    return 1000;
  endfunction

  task automatic random_phase(output int n);
    int pulse_pct;
    int tick_pct;
    load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), pick_window());
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    pulse_pct = $urandom_range(0, 100);
    tick_pct  = $urandom_range(5, 100);
    n = $urandom_range(30, 120);
    repeat (n)
      push_sample($urandom_range(0, 99) < pulse_pct, $urandom_range(0, 99) < tick_pct);
    settle();
  endtask

  initial begin : stimulus
    int random_items;
    int n;
    random_items = 0;
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    sample.valid = 1'b0;
    sample.pulse = 1'b0;
    sample.tick  = 1'b0;
    result.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // full gains, target 0, window 0: every tick closes a window at top drive
    load_settings(0, 255, 255, 255, 0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b1);
    settle();

    // zero gains, setting 255, window 1: drive pinned at the floor
    load_settings(255, 0, 0, 0, 1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b1);
    settle();

    // writes to unmapped indexes must leave everything alone
    for (int i = FIRST_UNMAPPED_INDEX; i < (1 << IDX_BITS); i++)
      write_setting(IDX_BITS'(i), $urandom_range(0, 65535));
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    settle();

    // unity proportional gain keeps the drive inside the clamp range
    load_settings(205, 1, 0, 0, 0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b1);
    settle();

    // reset defaults, window 100
    load_settings(mspid_pkg::TARGET_RESET, mspid_pkg::PROP_RESET, mspid_pkg::INT_RESET,
                  mspid_pkg::DERIV_RESET, mspid_pkg::WINDOW_RESET);
    repeat (3 * (mspid_pkg::WINDOW_RESET + 1))
      push_sample(1'($urandom_range(0, 1)), 1'b1);
    random_items += 3 * (mspid_pkg::WINDOW_RESET + 1);
    settle();

    // widest window: ticks keep counting and no window closes
    load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), 65535);
    repeat (WIDE_WINDOW_ITEMS) push_sample(1'($urandom_range(0, 1)), 1'b1);
    random_items += WIDE_WINDOW_ITEMS;
    settle();

    while (random_items < RANDOM_ITEMS) begin
      random_phase(n);
      random_items += n;
    end

    settle();
    if (errors == 0) begin
      $display("motor_speed_pid_loop_top_tb: clean");
    end else begin
      $display("motor_speed_pid_loop_top_tb: errors");
    end
    $finish;
  end

endmodule
